/* design/tti_pkg.sv */
// tti_pkg: shared types and constants for the text-to-integer parser.
// Holds the item structs, the parse phase encoding and character codes.
// No dependencies.
`default_nettype none

package tti_pkg;

    localparam int OUT_W = 32;
    localparam int UNIT_W = 16;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic signed [OUT_W-1:0] value_out_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_unit;
    } code_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] parsed_value;
        logic                    minus_seen;
    } result_item_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_HEX    = 3'd3,
        PH_DEC    = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    localparam unit_t CH_MINUS = 16'h002D;
    localparam unit_t CH_PLUS  = 16'h002B;
    localparam unit_t CH_ZERO  = 16'h0030;
    localparam unit_t CH_NINE  = 16'h0039;
    localparam unit_t CH_LX    = 16'h0078;
    localparam unit_t CH_UX    = 16'h0058;
    localparam unit_t CH_LA    = 16'h0061;
    localparam unit_t CH_LF    = 16'h0066;
    localparam unit_t CH_UA    = 16'h0041;
    localparam unit_t CH_UF    = 16'h0046;
    localparam logic [3:0] HEX_TEN = 4'hA;

endpackage

`default_nettype wire

/* design/tti_step.sv */
// tti_step: next-state and result logic for one code unit.
// Decodes signs, the hex prefix and digits; updates the accumulator.
// Depends on tti_pkg.
`default_nettype none

module tti_step #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire tti_pkg::code_item_t   item,
    input  wire tti_pkg::phase_t       phase,
    input  wire logic [VALUE_WIDTH-1:0] acc,
    input  wire logic                  neg,
    output tti_pkg::phase_t            phase_next,
    output logic [VALUE_WIDTH-1:0]     acc_next,
    output logic                       neg_next,
    output tti_pkg::result_item_t      result
);

    logic [15:0]            c;
    logic                   is_dec;
    logic                   is_hex;
    logic [3:0]             dec_digit;
    logic [3:0]             hex_digit;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [VALUE_WIDTH-1:0] acc_hex;
    tti_pkg::phase_t        ph;
    logic [VALUE_WIDTH-1:0] acc_upd;
    logic                   neg_upd;
    logic [VALUE_WIDTH-1:0] final_val;

    assign c = item.code_unit;
    assign is_dec = c inside {[tti_pkg::CH_ZERO:tti_pkg::CH_NINE]};
    assign dec_digit = c[3:0];

    always_comb
    begin
        is_hex = 1'b1;
        hex_digit = c[3:0];
        if (is_dec)
        begin
            hex_digit = c[3:0];
        end
        else if (c inside {[tti_pkg::CH_LA:tti_pkg::CH_LF]})
        begin
            hex_digit = 4'(c - tti_pkg::CH_LA) + tti_pkg::HEX_TEN;
        end
        else if (c inside {[tti_pkg::CH_UA:tti_pkg::CH_UF]})
        begin
            hex_digit = 4'(c - tti_pkg::CH_UA) + tti_pkg::HEX_TEN;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign acc_dec = (acc << 3) + (acc << 1) + VALUE_WIDTH'(dec_digit);
    assign acc_hex = (acc << 4) + VALUE_WIDTH'(hex_digit);

    always_comb
    begin
        ph = phase;
        acc_upd = acc;
        neg_upd = neg;
        case (phase)
            tti_pkg::PH_START, tti_pkg::PH_SIGNED:
            begin
                if (phase == tti_pkg::PH_START && c == tti_pkg::CH_MINUS)
                begin
                    neg_upd = 1'b1;
                    ph = tti_pkg::PH_SIGNED;
                end
                else if (phase == tti_pkg::PH_START && c == tti_pkg::CH_PLUS)
                begin
                    ph = tti_pkg::PH_SIGNED;
                end
                else if (c == tti_pkg::CH_ZERO)
                begin
                    ph = tti_pkg::PH_ZERO;
                end
                else if (is_dec)
                begin
                    acc_upd = acc_dec;
                    ph = tti_pkg::PH_DEC;
                end
                else
                begin
                    ph = tti_pkg::PH_DONE;
                end
            end
            tti_pkg::PH_ZERO:
            begin
                if (c inside {tti_pkg::CH_LX, tti_pkg::CH_UX})
                begin
                    ph = tti_pkg::PH_HEX;
                end
                else if (is_dec)
                begin
                    acc_upd = acc_dec;
                    ph = tti_pkg::PH_DEC;
                end
                else
                begin
                    ph = tti_pkg::PH_DONE;
                end
            end
            tti_pkg::PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_upd = acc_hex;
                end
                else
                begin
                    ph = tti_pkg::PH_DONE;
                end
            end
            tti_pkg::PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_upd = acc_dec;
                end
                else
                begin
                    ph = tti_pkg::PH_DONE;
                end
            end
            default:
            begin
                ph = phase;
            end
        endcase
    end

    assign final_val = neg_upd ? ('0 - acc_upd) : acc_upd;

    always_comb
    begin
        result.parsed_value = tti_pkg::value_out_t'(signed'(final_val));
        result.minus_seen = neg_upd;
        if (item.last_unit)
        begin
            phase_next = tti_pkg::PH_START;
            acc_next = '0;
            neg_next = 1'b0;
        end
        else
        begin
            phase_next = ph;
            acc_next = acc_upd;
            neg_next = neg_upd;
        end
    end

endmodule

`default_nettype wire

/* design/text_to_integer_parser_top.sv */
// text_to_integer_parser_top: streaming text-to-integer parser.
// Input register, tti_step logic, parse state and result register.
// Depends on tti_pkg and tti_step.
//
// Usage:
//   code channel (code_valid/code_ready/code) carries one 16-bit code unit
//   per item, with last_unit marking the end of a string. An optional sign,
//   an optional 0x/0X prefix and decimal or hex digits are parsed; the first
//   unit not accepted ends parsing until the end of the string.
//   result channel (result_valid/result_ready/result) carries one item per
//   string: the value wrapped modulo 2^VALUE_WIDTH, negated after a minus
//   sign and sign-extended or cut to 32 bits, plus the minus flag.
//   Path: an accepted unit is held in the input register and parsed from there
//   into the parse state; a final result goes to the result register.
//   Throughput: one unit per cycle while code_ready is high; the accumulator
//   update (shift by 4 or times ten, plus digit) is combinational.
//   Reset: parse state returns to the start of a string, both registers
//   empty. When the receiver stalls, the result register holds its item and
//   units without a result keep flowing; a final unit waits in the input
//   register, with code_ready low, until the result register frees up.
`default_nettype none

module text_to_integer_parser_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  code_valid,
    output logic                       code_ready,
    input  wire tti_pkg::code_item_t   code,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output tti_pkg::result_item_t      result
);

    logic                   in_vld_reg;
    tti_pkg::code_item_t    in_item_reg;
    tti_pkg::phase_t        phase_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic                   neg_reg;
    logic                   out_vld_reg;
    tti_pkg::result_item_t  out_item_reg;

    tti_pkg::phase_t        phase_next;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic                   neg_next;
    tti_pkg::result_item_t  step_result;

    logic out_free;
    logic advance;
    logic emit;

    tti_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .item       (in_item_reg),
        .phase      (phase_reg),
        .acc        (acc_reg),
        .neg        (neg_reg),
        .phase_next (phase_next),
        .acc_next   (acc_next),
        .neg_next   (neg_next),
        .result     (step_result)
    );

    assign out_free = !out_vld_reg || result_ready;
    assign advance = in_vld_reg && (!in_item_reg.last_unit || out_free);
    assign emit = advance && in_item_reg.last_unit;
    assign code_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg <= tti_pkg::PH_START;
            acc_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            if (code_ready)
            begin
                in_vld_reg <= code_valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                acc_reg <= acc_next;
                neg_reg <= neg_next;
            end
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_ready && code_valid)
        begin
            in_item_reg <= code;
        end
        if (emit)
        begin
            out_item_reg <= step_result;
        end
    end

    assign result_valid = out_vld_reg;
    assign result = out_item_reg;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// testbench: self-checking bench for text_to_integer_parser_top.
// Drives strings of code units over valid/ready and checks each parsed result
// against an in-bench predictor. Depends on tti_pkg and the parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class parse_scoreboard;
        tti_pkg::phase_t        phase;
        logic [31:0]            acc;
        bit                     neg;
        tti_pkg::result_item_t  expected_values[$];
        int                     errors;

        function new();
            phase = tti_pkg::PH_START;
            acc = '0;
            neg = 1'b0;
            errors = 0;
        endfunction

        function bit is_decimal(tti_pkg::unit_t c);
            return c inside {[tti_pkg::CH_ZERO:tti_pkg::CH_NINE]};
        endfunction

        function void add_decimal(tti_pkg::unit_t c);
            acc = acc * 32'd10 + 32'(c - tti_pkg::CH_ZERO);
        endfunction

        // unit right after an optional sign
        function void lead_unit(tti_pkg::unit_t c);
            if (c == tti_pkg::CH_ZERO)
                phase = tti_pkg::PH_ZERO;
            else if (is_decimal(c))
            begin
                add_decimal(c);
                phase = tti_pkg::PH_DEC;
            end
            else
                phase = tti_pkg::PH_DONE;
        endfunction

        function void note_unit(tti_pkg::code_item_t it);
            tti_pkg::unit_t         c;
            logic [3:0]             digit;
            bit                     is_hex;
            tti_pkg::result_item_t  r;
            c = it.code_unit;
            case (phase)
                tti_pkg::PH_START:
                begin
                    if (c == tti_pkg::CH_MINUS)
                    begin
                        neg = 1'b1;
                        phase = tti_pkg::PH_SIGNED;
                    end
                    else if (c == tti_pkg::CH_PLUS)
                        phase = tti_pkg::PH_SIGNED;
                    else
                        lead_unit(c);
                end
                tti_pkg::PH_SIGNED:
                    lead_unit(c);
                tti_pkg::PH_ZERO:
                begin
                    if (c inside {tti_pkg::CH_LX, tti_pkg::CH_UX})
                        phase = tti_pkg::PH_HEX;
                    else if (is_decimal(c))
                    begin
                        add_decimal(c);
                        phase = tti_pkg::PH_DEC;
                    end
                    else
                        phase = tti_pkg::PH_DONE;
                end
                tti_pkg::PH_HEX:
                begin
                    is_hex = 1'b1;
                    digit = '0;
                    if (is_decimal(c))
                        digit = 4'(c - tti_pkg::CH_ZERO);
                    else if (c inside {[tti_pkg::CH_LA:tti_pkg::CH_LF]})
                        digit = 4'(c - tti_pkg::CH_LA) + tti_pkg::HEX_TEN;
                    else if (c inside {[tti_pkg::CH_UA:tti_pkg::CH_UF]})
                        digit = 4'(c - tti_pkg::CH_UA) + tti_pkg::HEX_TEN;
                    else
                        is_hex = 1'b0;
                    if (is_hex)
                        acc = {acc[27:0], digit};
                    else
                        phase = tti_pkg::PH_DONE;
                end
                tti_pkg::PH_DEC:
                begin
                    if (is_decimal(c))
                        add_decimal(c);
                    else
                        phase = tti_pkg::PH_DONE;
                end
                default:
                    ;
            endcase
            if (it.last_unit)
            begin
                r.parsed_value = neg ? -acc : acc;
                r.minus_seen = neg;
                expected_values.push_back(r);
                phase = tti_pkg::PH_START;
                acc = '0;
                neg = 1'b0;
            end
        endfunction

        function void check_result(tti_pkg::result_item_t got);
            tti_pkg::result_item_t want;
            if (expected_values.size() == 0)
            begin
                $display("%0t: result with no pending string: value %0d minus %0b",
                         $time, got.parsed_value, got.minus_seen);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (got.parsed_value !== want.parsed_value)
            begin
                $display("%0t: parsed_value expected %0d (%h) actual %0d (%h)", $time,
                         want.parsed_value, want.parsed_value,
                         got.parsed_value, got.parsed_value);
                errors++;
            end
            if (got.minus_seen !== want.minus_seen)
            begin
                $display("%0t: minus_seen expected %0b actual %0b",
                         $time, want.minus_seen, got.minus_seen);
                errors++;
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    localparam int UNIT_COUNT  = 1200;
    localparam int CALM_FROM   = 1020;

    logic                   clk;
    logic                   rst_n;
    logic                   code_valid;
    logic                   code_ready;
    tti_pkg::code_item_t    code;
    logic                   result_valid;
    logic                   result_ready;
    tti_pkg::result_item_t  result;

    parse_scoreboard sb = new();
    tti_pkg::unit_t  text_q[$];
    int     units_sent = 0;
    int     idle_pct = 0;
    bit     quiet = 1'b0;

    text_to_integer_parser_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_ready   (code_ready),
        .code         (code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("text_to_integer_parser_top verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            sb.check_result(result);
        if (code_valid && code_ready)
            sb.note_unit(code);
    end

    initial
    begin
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            result_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 30))
                @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    task automatic send_text();
        tti_pkg::code_item_t it;
        for (int i = 0; i < text_q.size(); i++)
        begin
            it.code_unit = text_q[i];
            it.last_unit = (i == text_q.size() - 1);
            if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                code_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            code_valid <= 1'b1;
            code <= it;
            do
                @(posedge clk);
            while (!code_ready);
            units_sent++;
        end
        text_q.delete();
    endtask

    task automatic send_ascii(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(tti_pkg::unit_t'(s[i]));
        send_text();
    endtask

    function automatic tti_pkg::unit_t odd_unit();
        tti_pkg::unit_t pool[$] = '{tti_pkg::CH_MINUS, tti_pkg::CH_PLUS,
                                    tti_pkg::CH_LX, tti_pkg::CH_UX,
                                    tti_pkg::CH_ZERO, tti_pkg::CH_NINE,
                                    tti_pkg::CH_LA, tti_pkg::CH_LF,
                                    tti_pkg::CH_UA, tti_pkg::CH_UF,
                                    16'h0067, 16'h0047, 16'h002F, 16'h003A,
                                    16'h0040, 16'h0060, 16'h0000, 16'h0020};
        if ($urandom_range(0, 1))
            return tti_pkg::unit_t'($urandom_range(0, 65535));
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic build_random_text();
        int     ndig;
        int     v;
        int     pos;
        case ($urandom_range(0, 3))
            0: text_q.push_back(tti_pkg::CH_MINUS);
            1: text_q.push_back(tti_pkg::CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            text_q.push_back(tti_pkg::CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? tti_pkg::CH_LX : tti_pkg::CH_UX);
            ndig = $urandom_range(0, 10);
            repeat (ndig)
            begin
                v = $urandom_range(0, 15);
                if (v < 10)
                    text_q.push_back(tti_pkg::CH_ZERO + tti_pkg::unit_t'(v));
                else
                    text_q.push_back(($urandom_range(0, 1) ? tti_pkg::CH_LA : tti_pkg::CH_UA)
                                     + tti_pkg::unit_t'(v - 10));
            end
        end
        else
        begin
            ndig = $urandom_range(1, 12);
            repeat (ndig)
                text_q.push_back(tti_pkg::CH_ZERO + tti_pkg::unit_t'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    pos = $urandom_range(0, text_q.size());
                    text_q.insert(pos, odd_unit());
                end
                1:
                    repeat ($urandom_range(1, 4))
                        text_q.push_back(odd_unit());
                default:
                begin
                    text_q.delete();
                    repeat ($urandom_range(1, 6))
                        text_q.push_back(odd_unit());
                end
            endcase
        end
    endtask

    initial
    begin
        int guard;
        code_valid <= 1'b0;
        code <= '0;
        @(posedge rst_n);
        @(posedge clk);

        send_ascii("0x");
        send_ascii("-0x1F");
        send_ascii("+09");
        send_ascii("--5");
        send_ascii("0");
        send_ascii("0Xa");
        send_ascii("9z");
        text_q.push_back(16'h0000);
        text_q.push_back(16'h0037);
        send_text();
        text_q.push_back(16'hFFFF);
        send_text();

        while (units_sent < UNIT_COUNT)
        begin
            if (units_sent >= CALM_FROM)
                quiet = 1'b1;
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 40;
            endcase
            build_random_text();
            send_text();
        end
        code_valid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors += sb.pending();
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("text_to_integer_parser_top verification clean");
        else
            $display("text_to_integer_parser_top verification failed");
        $finish;
    end
endmodule
